FILE: rtl/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg: shared types and constants of the grid raycaster
// Constants, divider transaction types and small helpers used by the
// raycaster's modules.
// ----------------------------------------------------------------------------
package rcw_pkg;

	// Default geometry, handed to the top level's parameters.
	localparam int MAP_COLS_DEF  = 64;
	localparam int MAP_ROWS_DEF  = 64;
	localparam int MAX_STEPS_DEF = 96;

	localparam int MAX_COLUMNS = 640;
	localparam int TEX_BITS    = 5;
	localparam int CELL_W      = 5;

	// Fixed-point constants (Q16.16).
	localparam int unsigned FOV_Q      = 43254;
	localparam int unsigned MIN_PERP   = 3277;
	localparam int unsigned PERP_CAP   = 6291456;
	// Smallest distance at which the light reaches its floor value.
	localparam int unsigned LIGHT_FLOOR_PERP = 964267;
	localparam int unsigned LIGHT_BASE = 1677721600;
	localparam int unsigned LIGHT_MIN  = 30;

	// Cell hash multipliers.
	localparam logic [31:0] HASH_A = 32'd73856093;
	localparam logic [31:0] HASH_B = 32'd19349663;
	localparam logic [31:0] HASH_C = 32'h7feb352d;
	localparam logic [31:0] HASH_D = 32'h846ca68b;

	// Divider widths: dividend and divisor.
	localparam int DIV_NW = 33;
	localparam int DIV_DW = 44;

	typedef enum logic [2:0] {
		CFG_PLAYER_X  = 3'd0,
		CFG_PLAYER_Y  = 3'd1,
		CFG_FACING_X  = 3'd2,
		CFG_FACING_Y  = 3'd3,
		CFG_VIEW_W    = 3'd4,
		CFG_VIEW_H    = 3'd5,
		CFG_TEX_COUNT = 3'd6,
		CFG_DOOR_KIND = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic              go;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
		logic [DIV_DW-1:0] rem;
	} div_rsp_t;

	// Facing code: 01 is +1, 00 is 0, anything else is -1.
	function automatic logic signed [1:0] facing_dec(input logic [1:0] v);
		logic signed [1:0] r;
		unique case (v)
			2'b01:   r = 2'sd1;
			2'b00:   r = 2'sd0;
			default: r = -2'sd1;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/rcw_ram.sv
// ----------------------------------------------------------------------------
// rcw_ram: generic single-port synchronous RAM
// One address per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module rcw_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [W-1:0]             wdata,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/rcw_div.sv
// ----------------------------------------------------------------------------
// rcw_div: iterative unsigned divider
// Restoring radix-2 division, one quotient bit per cycle, giving quotient and
// remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module rcw_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rcw_pkg::div_req_t req,
	output rcw_pkg::div_rsp_t rsp
);

	localparam int NW = rcw_pkg::DIV_NW;
	localparam int DW = rcw_pkg::DIV_DW;
	localparam int CW = $clog2(NW);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	logic [DW:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				rem_q <= '0;
				quo_q <= req.num;
				den_q <= req.den;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= fits ? DW'(trial - {1'b0, den_q}) : DW'(trial);
				quo_q <= {quo_q[NW-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

FILE: rtl/raycast_wall_column_top.sv
// ----------------------------------------------------------------------------
// raycast_wall_column_top: grid raycaster, one wall column per cast
// Holds the tile map and traces one screen column per cast command.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A map-write command
// leaves the block idle and gives no result. A cast command whose column lies
// inside the view gives exactly one result, shown for a single cycle with done
// high; the receiver cannot hold it off, so it must take every result as it
// comes. A cast keeps busy high until its result is registered: the shared
// divider runs up to five times per cast (camera offset, two step deltas,
// wall height and texture hash), skipped for a zero ray component or when no
// texture is chosen, and the map memory is read once per grid step, with
// registered read data, for at most MAX_STEPS steps. After reset the block
// clears all MAP_COLS*MAP_ROWS cells (4096 by default), one cell per cycle,
// with busy held high; configuration writes are taken throughout and should
// only be made while busy is low and no result is outstanding.
// ----------------------------------------------------------------------------
module raycast_wall_column_top #(
	parameter int MAP_COLS  = rcw_pkg::MAP_COLS_DEF,
	parameter int MAP_ROWS  = rcw_pkg::MAP_ROWS_DEF,
	parameter int MAX_STEPS = rcw_pkg::MAX_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command channel.
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [5:0]  cell_x,
	input  logic [5:0]  cell_y,
	input  logic [3:0]  cell_kind,
	input  logic        cell_blocks,
	input  logic [9:0]  column,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_wdata,
	// Result channel.
	output logic        done,
	output logic        out_of_map,
	output logic [3:0]  hit_kind,
	output logic        hit_side,
	output logic [22:0] perp_dist,
	output logic [13:0] line_height,
	output logic [10:0] draw_top,
	output logic [10:0] draw_bottom,
	output logic [4:0]  tex_column,
	output logic        is_door,
	output logic [3:0]  texture_index,
	output logic [8:0]  light
);

	localparam int DEPTH = MAP_COLS * MAP_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(MAX_STEPS + 1);
	localparam int DW    = rcw_pkg::DIV_DW;
	localparam int NW    = rcw_pkg::DIV_NW;
	localparam int TB    = rcw_pkg::TEX_BITS;

	typedef enum logic [19:0] {
		S_CLEAR = 20'h00001,
		S_IDLE  = 20'h00002,
		S_CAM   = 20'h00004,
		S_RAY   = 20'h00008,
		S_DX    = 20'h00010,
		S_DY    = 20'h00020,
		S_INIT  = 20'h00040,
		S_STEP  = 20'h00080,
		S_READ  = 20'h00100,
		S_PERP  = 20'h00200,
		S_LINE  = 20'h00400,
		S_TEX   = 20'h00800,
		S_HA    = 20'h01000,
		S_HB    = 20'h02000,
		S_HC    = 20'h04000,
		S_MOD   = 20'h08000,
		S_LA    = 20'h10000,
		S_LB    = 20'h20000,
		S_LC    = 20'h40000,
		S_OUT   = 20'h80000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [5:0]  px_q, py_q;
	logic [1:0]  fxc_q, fyc_q;
	logic [9:0]  vw_q;
	logic [10:0] vh_q;
	logic [4:0]  ntc_q;
	logic [3:0]  door_q;

	// Ray state.
	logic [AW-1:0]      clr_q;
	logic               issued_q;
	logic [9:0]         col_q;
	logic signed [17:0] cam_q;
	logic signed [18:0] rdx_q, rdy_q;
	logic [DW-1:0]      dxd_q, dyd_q, sx_q, sy_q, perp_q;
	logic signed [9:0]  mx_q, my_q;
	logic               side_q, oob_q, hit_q;
	logic [3:0]         kind_q;
	logic [SW-1:0]      cnt_q;
	logic [13:0]        line_q;
	logic [10:0]        top_q, bot_q;
	logic [31:0]        tprod_q, hash_q;
	logic [TB-1:0]      tx_q;
	logic [3:0]         ntex_q;
	logic [14:0]        lv_q;
	logic               lbig_q;
	logic [8:0]         q0_q, lm_q;

	// Result registers.
	logic        done_q, oob_o_q, side_o_q, door_o_q;
	logic [3:0]  kind_o_q, tex_o_q;
	logic [22:0] perp_o_q;
	logic [13:0] line_o_q;
	logic [10:0] top_o_q, bot_o_q;
	logic [4:0]  tx_o_q;
	logic [8:0]  light_o_q;

	logic accept;
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// ------------------------------------------------------------------
	// Configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q   <= '0;
			py_q   <= '0;
			fxc_q  <= 2'b00;
			fyc_q  <= 2'b11;
			vw_q   <= 10'd320;
			vh_q   <= 11'd200;
			ntc_q  <= 5'd1;
			door_q <= 4'd2;
		end else if (cfg_we) begin
			unique case (rcw_pkg::cfg_idx_t'(cfg_index))
				rcw_pkg::CFG_PLAYER_X:  px_q   <= cfg_wdata[5:0];
				rcw_pkg::CFG_PLAYER_Y:  py_q   <= cfg_wdata[5:0];
				rcw_pkg::CFG_FACING_X:  fxc_q  <= cfg_wdata[1:0];
				rcw_pkg::CFG_FACING_Y:  fyc_q  <= cfg_wdata[1:0];
				rcw_pkg::CFG_VIEW_W:    vw_q   <= cfg_wdata[9:0];
				rcw_pkg::CFG_VIEW_H:    vh_q   <= cfg_wdata;
				rcw_pkg::CFG_TEX_COUNT: ntc_q  <= cfg_wdata[4:0];
				rcw_pkg::CFG_DOOR_KIND: door_q <= cfg_wdata[3:0];
			endcase
		end
	end

	// Effective view width: zero counts as one, wide views are capped.
	logic [9:0] vw_eff;
	always_comb begin
		if (vw_q == '0) begin
			vw_eff = 10'd1;
		end else if (32'(vw_q) > rcw_pkg::MAX_COLUMNS) begin
			vw_eff = 10'(rcw_pkg::MAX_COLUMNS);
		end else begin
			vw_eff = vw_q;
		end
	end

	// Facing: both zero counts as looking up the map (y = -1).
	logic signed [1:0] fx_d, fy_d;
	logic              fx_pos, fx_neg, fy_pos, fy_neg;
	always_comb begin
		fx_d = rcw_pkg::facing_dec(fxc_q);
		fy_d = rcw_pkg::facing_dec(fyc_q);
		if (fx_d == 2'sd0 && fy_d == 2'sd0) begin
			fy_d = -2'sd1;
		end
	end
	assign fx_pos = (fx_d == 2'sd1);
	assign fx_neg = (fx_d == -2'sd1);
	assign fy_pos = (fy_d == 2'sd1);
	assign fy_neg = (fy_d == -2'sd1);

	// ------------------------------------------------------------------
	// Ray direction from the camera offset
	// ------------------------------------------------------------------
	logic signed [34:0] fov_prod, fov_neg, shp, shn;
	logic signed [18:0] rdx_n, rdy_n, termx, termy;
	always_comb begin
		fov_prod = 35'(18'sd43254) * 35'(cam_q);
		fov_neg  = -fov_prod;
		shp      = fov_prod >>> 16;
		shn      = fov_neg >>> 16;
		termx    = fy_pos ? 19'(shn) : (fy_neg ? 19'(shp) : 19'sd0);
		termy    = fx_pos ? 19'(shp) : (fx_neg ? 19'(shn) : 19'sd0);
		rdx_n    = (fx_pos ? 19'sd65536 : (fx_neg ? -19'sd65536 : 19'sd0)) + termx;
		rdy_n    = (fy_pos ? 19'sd65536 : (fy_neg ? -19'sd65536 : 19'sd0)) + termy;
	end

	logic [18:0] rdx_abs, rdy_abs;
	assign rdx_abs = rdx_q[18] ? 19'(-rdx_q) : 19'(rdx_q);
	assign rdy_abs = rdy_q[18] ? 19'(-rdy_q) : 19'(rdy_q);

	// ------------------------------------------------------------------
	// One DDA step
	// ------------------------------------------------------------------
	logic              step_x, oob_n;
	logic signed [9:0] mx_n, my_n;
	logic [AW-1:0]     step_addr;
	always_comb begin
		step_x = sx_q < sy_q;
		mx_n   = mx_q;
		my_n   = my_q;
		if (step_x) begin
			mx_n = rdx_q[18] ? mx_q - 10'sd1 : mx_q + 10'sd1;
		end else begin
			my_n = rdy_q[18] ? my_q - 10'sd1 : my_q + 10'sd1;
		end
		oob_n = (mx_n < 10'sd0) || (my_n < 10'sd0)
			|| (int'(mx_n) >= MAP_COLS) || (int'(my_n) >= MAP_ROWS);
		step_addr = AW'(int'(my_n) * MAP_COLS + int'(mx_n));
	end

	// ------------------------------------------------------------------
	// Map memory
	// ------------------------------------------------------------------
	logic                       ram_we;
	logic [AW-1:0]              ram_addr;
	logic [rcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
	logic                       wr_in_map;
	logic [AW-1:0]              wr_addr;

	assign wr_in_map = (int'(cell_x) < MAP_COLS) && (int'(cell_y) < MAP_ROWS);
	assign wr_addr   = AW'(int'(cell_y) * MAP_COLS + int'(cell_x));

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = step_addr;
		ram_wdata = {cell_blocks, cell_kind};
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_addr  = clr_q;
			ram_wdata = '0;
		end else if (state_q == S_IDLE) begin
			ram_we   = accept && !action && wr_in_map;
			ram_addr = wr_addr;
		end
	end

	rcw_ram #(
		.W     (rcw_pkg::CELL_W),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Shared divider
	// ------------------------------------------------------------------
	rcw_pkg::div_req_t div_req;
	rcw_pkg::div_rsp_t div_rsp;

	logic        door_w, tex_skip;
	logic [4:0]  ntex_n;
	logic [31:0] hash_fin;

	assign door_w   = hit_q && (kind_q == door_q);
	assign ntex_n   = (ntc_q > 5'd16) ? 5'd16 : ntc_q;
	assign tex_skip = door_w || (ntex_n == '0);
	assign hash_fin = hash_q ^ (hash_q >> 16);

	always_comb begin
		div_req.go  = 1'b0;
		div_req.num = NW'(hash_fin);
		div_req.den = DW'(ntex_n);
		unique case (state_q)
			S_CAM: begin
				div_req.go  = !issued_q;
				div_req.num = NW'(col_q) << 17;
				div_req.den = DW'(vw_eff);
			end
			S_DX: begin
				div_req.go  = !issued_q && (rdx_q != '0);
				div_req.num = NW'(1) << 32;
				div_req.den = DW'(rdx_abs);
			end
			S_DY: begin
				div_req.go  = !issued_q && (rdy_q != '0);
				div_req.num = NW'(1) << 32;
				div_req.den = DW'(rdy_abs);
			end
			S_LINE: begin
				div_req.go  = !issued_q;
				div_req.num = NW'(vh_q) << 16;
				div_req.den = perp_q;
			end
			S_MOD: begin
				div_req.go = !issued_q && !tex_skip;
			end
			default: begin
				div_req.go = 1'b0;
			end
		endcase
	end

	rcw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------
	// Distance, span, texture and light helpers
	// ------------------------------------------------------------------
	logic [DW-1:0] perp_raw, perp_n;
	assign perp_raw = side_q ? (sy_q - dyd_q) : (sx_q - dxd_q);
	assign perp_n   = (perp_raw < DW'(rcw_pkg::MIN_PERP)) ? DW'(rcw_pkg::MIN_PERP)
		: perp_raw;

	logic [13:0] line_cap;
	assign line_cap = {vh_q, 3'b000};

	logic signed [16:0] line_s, vh_s, start_s, half_s, end_s;
	always_comb begin
		line_s  = 17'($signed({1'b0, line_q}));
		vh_s    = 17'($signed({1'b0, vh_q}));
		start_s = vh_s - line_s;
		// Halve with truncation toward zero.
		half_s  = (start_s < 17'sd0) ? -((-start_s) >>> 1) : (start_s >>> 1);
		end_s   = half_s + line_s;
	end

	logic [31:0] ray32;
	assign ray32 = side_q ? 32'(rdx_q) : 32'(rdy_q);

	logic [15:0] w16;
	logic        mirror;
	assign w16    = tprod_q[31:16] + 16'h8000;
	assign mirror = (!side_q && (rdx_q > 19'sd0)) || (side_q && rdy_q[18]);

	logic [31:0] hx32, hy32, hash_a;
	assign hx32   = 32'(mx_q);
	assign hy32   = 32'(my_q);
	assign hash_a = (hx32 * rcw_pkg::HASH_A) ^ (hy32 * rcw_pkg::HASH_B);

	logic [31:0] lp32, lnum;
	assign lp32 = 32'(perp_q[19:0]);
	assign lnum = rcw_pkg::LIGHT_BASE - ((lp32 << 9) + (lp32 << 10));

	logic [15:0] lrem;
	assign lrem = 16'(lv_q) - (16'(q0_q) * 16'd100);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			issued_q  <= 1'b0;
			col_q     <= '0;
			cam_q     <= '0;
			rdx_q     <= '0;
			rdy_q     <= '0;
			dxd_q     <= '0;
			dyd_q     <= '0;
			sx_q      <= '0;
			sy_q      <= '0;
			perp_q    <= '0;
			mx_q      <= '0;
			my_q      <= '0;
			side_q    <= 1'b0;
			oob_q     <= 1'b0;
			hit_q     <= 1'b0;
			kind_q    <= '0;
			cnt_q     <= '0;
			line_q    <= '0;
			top_q     <= '0;
			bot_q     <= '0;
			tprod_q   <= '0;
			hash_q    <= '0;
			tx_q      <= '0;
			ntex_q    <= '0;
			lv_q      <= '0;
			lbig_q    <= 1'b0;
			q0_q      <= '0;
			lm_q      <= '0;
			done_q    <= 1'b0;
			oob_o_q   <= 1'b0;
			side_o_q  <= 1'b0;
			door_o_q  <= 1'b0;
			kind_o_q  <= '0;
			tex_o_q   <= '0;
			perp_o_q  <= '0;
			line_o_q  <= '0;
			top_o_q   <= '0;
			bot_o_q   <= '0;
			tx_o_q    <= '0;
			light_o_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && action && (column < vw_eff)) begin
						col_q    <= column;
						hit_q    <= 1'b0;
						oob_q    <= 1'b0;
						kind_q   <= '0;
						issued_q <= 1'b0;
						state_q  <= S_CAM;
					end
				end
				S_CAM: begin
					if (div_req.go) begin
						issued_q <= 1'b1;
					end
					if (div_rsp.done) begin
						cam_q    <= $signed(18'(div_rsp.quo)) - 18'sd65536;
						issued_q <= 1'b0;
						state_q  <= S_RAY;
					end
				end
				S_RAY: begin
					rdx_q   <= rdx_n;
					rdy_q   <= rdy_n;
					state_q <= S_DX;
				end
				S_DX: begin
					if (rdx_q == '0) begin
						// A zero component never crosses a line: infinite step.
						dxd_q   <= DW'(1) << 40;
						state_q <= S_DY;
					end else begin
						if (div_req.go) begin
							issued_q <= 1'b1;
						end
						if (div_rsp.done) begin
							dxd_q    <= DW'(div_rsp.quo);
							issued_q <= 1'b0;
							state_q  <= S_DY;
						end
					end
				end
				S_DY: begin
					if (rdy_q == '0) begin
						dyd_q   <= DW'(1) << 40;
						state_q <= S_INIT;
					end else begin
						if (div_req.go) begin
							issued_q <= 1'b1;
						end
						if (div_rsp.done) begin
							dyd_q    <= DW'(div_rsp.quo);
							issued_q <= 1'b0;
							state_q  <= S_INIT;
						end
					end
				end
				S_INIT: begin
					sx_q    <= dxd_q >> 1;
					sy_q    <= dyd_q >> 1;
					mx_q    <= 10'(px_q);
					my_q    <= 10'(py_q);
					cnt_q   <= '0;
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (step_x) begin
						sx_q   <= sx_q + dxd_q;
						side_q <= 1'b0;
					end else begin
						sy_q   <= sy_q + dyd_q;
						side_q <= 1'b1;
					end
					mx_q  <= mx_n;
					my_q  <= my_n;
					cnt_q <= cnt_q + 1'b1;
					if (oob_n) begin
						oob_q   <= 1'b1;
						state_q <= S_PERP;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (ram_rdata[rcw_pkg::CELL_W-1]) begin
						hit_q   <= 1'b1;
						kind_q  <= ram_rdata[3:0];
						state_q <= S_PERP;
					end else if (cnt_q == SW'(MAX_STEPS)) begin
						state_q <= S_PERP;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_PERP: begin
					perp_q   <= perp_n;
					issued_q <= 1'b0;
					state_q  <= S_LINE;
				end
				S_LINE: begin
					if (div_req.go) begin
						issued_q <= 1'b1;
					end
					if (div_rsp.done) begin
						line_q   <= (div_rsp.quo > NW'(line_cap)) ? line_cap
							: 14'(div_rsp.quo);
						issued_q <= 1'b0;
						state_q  <= S_TEX;
					end
				end
				S_TEX: begin
					top_q   <= (half_s < 17'sd0) ? 11'd0 : 11'(half_s);
					bot_q   <= (end_s > vh_s) ? vh_q : 11'(end_s);
					tprod_q <= perp_q[31:0] * ray32;
					state_q <= S_HA;
				end
				S_HA: begin
					tx_q    <= mirror ? ~w16[15 -: TB] : w16[15 -: TB];
					hash_q  <= hash_a;
					state_q <= S_HB;
				end
				S_HB: begin
					hash_q  <= (hash_q ^ (hash_q >> 16)) * rcw_pkg::HASH_C;
					state_q <= S_HC;
				end
				S_HC: begin
					hash_q   <= (hash_q ^ (hash_q >> 15)) * rcw_pkg::HASH_D;
					issued_q <= 1'b0;
					state_q  <= S_MOD;
				end
				S_MOD: begin
					if (tex_skip) begin
						ntex_q  <= '0;
						state_q <= S_LA;
					end else begin
						if (div_req.go) begin
							issued_q <= 1'b1;
						end
						if (div_rsp.done) begin
							ntex_q   <= div_rsp.rem[3:0];
							issued_q <= 1'b0;
							state_q  <= S_LA;
						end
					end
				end
				S_LA: begin
					lbig_q  <= perp_q >= DW'(rcw_pkg::LIGHT_FLOOR_PERP);
					lv_q    <= 15'(lnum >> 16);
					state_q <= S_LB;
				end
				S_LB: begin
					// Reciprocal of 100, low by at most one.
					q0_q    <= 9'((25'(lv_q) * 25'd655) >> 16);
					state_q <= S_LC;
				end
				S_LC: begin
					if (lbig_q) begin
						lm_q <= 9'(rcw_pkg::LIGHT_MIN);
					end else if (lrem >= 16'd100) begin
						lm_q <= q0_q + 9'd1;
					end else begin
						lm_q <= q0_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					done_q    <= 1'b1;
					oob_o_q   <= oob_q;
					kind_o_q  <= hit_q ? kind_q : 4'd0;
					side_o_q  <= side_q;
					perp_o_q  <= (perp_q > DW'(rcw_pkg::PERP_CAP))
						? 23'(rcw_pkg::PERP_CAP) : perp_q[22:0];
					line_o_q  <= line_q;
					top_o_q   <= top_q;
					bot_o_q   <= bot_q;
					tx_o_q    <= 5'(tx_q);
					door_o_q  <= door_w;
					tex_o_q   <= ntex_q;
					// Y-side walls are shaded to 180/256.
					light_o_q <= side_q ? 9'((17'(lm_q) * 17'd180) >> 8) : lm_q;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign out_of_map    = oob_o_q;
	assign hit_kind      = kind_o_q;
	assign hit_side      = side_o_q;
	assign perp_dist     = perp_o_q;
	assign line_height   = line_o_q;
	assign draw_top      = top_o_q;
	assign draw_bottom   = bot_o_q;
	assign tex_column    = tx_o_q;
	assign is_door       = door_o_q;
	assign texture_index = tex_o_q;
	assign light         = light_o_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_OUT))
		else $error("result strobe without a finished cast");

	a_ram_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_IDLE))
		else $error("map written while a ray is traced");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (int'(cnt_q) <= MAX_STEPS))
		else $error("ray ran past the step limit");

	a_step_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP) |-> (!oob_q && !hit_q))
		else $error("ray stepped after it ended");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the grid raycaster wall column block
// Drives map writes and column casts through the command port, retunes the
// player, view and texture registers between phases, and checks every result
// transaction against an independent fixed-point model of the ray march.
// ----------------------------------------------------------------------------

// One result transaction, as seen on the result ports.
typedef struct packed {
	logic        out_of_map;
	logic [3:0]  hit_kind;
	logic        hit_side;
	logic [22:0] perp_dist;
	logic [13:0] line_height;
	logic [10:0] draw_top;
	logic [10:0] draw_bottom;
	logic [4:0]  tex_column;
	logic        is_door;
	logic [3:0]  texture_index;
	logic [8:0]  light;
} column_result_t;

// One command transaction.
typedef struct packed {
	logic       action;
	logic [5:0] cell_x;
	logic [5:0] cell_y;
	logic [3:0] cell_kind;
	logic       cell_blocks;
	logic [9:0] column;
} raycast_cmd_t;

class column_scoreboard;
	// Shadow map: bit 4 blocks sight, bits 3:0 hold the tile kind.
	logic [4:0]     tiles [4096];
	logic [5:0]     pos_x, pos_y;
	logic [1:0]     face_x, face_y;
	logic [9:0]     view_w;
	logic [10:0]    view_h;
	logic [4:0]     tex_count;
	logic [3:0]     door_code;
	column_result_t expected_columns [$];
	int             mismatches;

	function new();
		foreach (tiles[i])
			tiles[i] = '0;
		pos_x = 0;
		pos_y = 0;
		face_x = 2'b00;
		face_y = 2'b11;
		view_w = 320;
		view_h = 200;
		tex_count = 1;
		door_code = 2;
		mismatches = 0;
	endfunction

	function void write_reg(rcw_pkg::cfg_idx_t idx, logic [10:0] v);
		case (idx)
			rcw_pkg::CFG_PLAYER_X:  pos_x = v[5:0];
			rcw_pkg::CFG_PLAYER_Y:  pos_y = v[5:0];
			rcw_pkg::CFG_FACING_X:  face_x = v[1:0];
			rcw_pkg::CFG_FACING_Y:  face_y = v[1:0];
			rcw_pkg::CFG_VIEW_W:    view_w = v[9:0];
			rcw_pkg::CFG_VIEW_H:    view_h = v[10:0];
			rcw_pkg::CFG_TEX_COUNT: tex_count = v[4:0];
			rcw_pkg::CFG_DOOR_KIND: door_code = v[3:0];
			default: ;
		endcase
	endfunction

	function longint facing_value(logic [1:0] v);
		if (v == 2'b01)
			return 1;
		if (v == 2'b00)
			return 0;
		return -1;
	endfunction

	function longint step_delta(longint r);
		longint a;
		if (r == 0)
			return longint'(1) << 40;
		a = (r < 0) ? -r : r;
		return (longint'(1) << 32) / a;
	endfunction

	function logic [31:0] tile_hash(int x, int y);
		logic [31:0] h;
		h = (32'(x) * rcw_pkg::HASH_A) ^ (32'(y) * rcw_pkg::HASH_B);
		h = h ^ (h >> 16);
		h = h * rcw_pkg::HASH_C;
		h = h ^ (h >> 15);
		h = h * rcw_pkg::HASH_D;
		h = h ^ (h >> 16);
		return h;
	endfunction

	// Notes an accepted command; a cast inside the view queues its column.
	function void note_command(raycast_cmd_t c);
		longint vw, vh, fx, fy, cam, rdx, rdy, dxd, dyd, sx, sy, perp, w, lm, num;
		longint line, top_raw, bot_raw, pxq, pyq, n;
		int mx, my, stx, sty, side, oob, hit, door;
		logic [3:0] kind;
		logic [4:0] c5;
		logic [31:0] tx;
		column_result_t r;
		oob = 0;
		hit = 0;
		door = 0;
		side = 0;
		kind = 0;
		if (!c.action) begin
			tiles[{c.cell_y, c.cell_x}] = {c.cell_blocks, c.cell_kind};
			return;
		end
		vw = view_w;
		if (vw == 0)
			vw = 1;
		if (vw > rcw_pkg::MAX_COLUMNS)
			vw = rcw_pkg::MAX_COLUMNS;
		if (longint'(c.column) >= vw)
			return;
		vh = view_h;
		fx = facing_value(face_x);
		fy = facing_value(face_y);
		if (fx == 0 && fy == 0)
			fy = -1;
		cam = ((longint'(c.column) << 17) / vw) - 65536;
		rdx = fx * 65536 + ((-fy * 43254 * cam) >>> 16);
		rdy = fy * 65536 + ((fx * 43254 * cam) >>> 16);
		dxd = step_delta(rdx);
		dyd = step_delta(rdy);
		stx = (rdx < 0) ? -1 : 1;
		sty = (rdy < 0) ? -1 : 1;
		sx = dxd >>> 1;
		sy = dyd >>> 1;
		mx = pos_x;
		my = pos_y;
		pxq = longint'(pos_x) * 65536 + 32768;
		pyq = longint'(pos_y) * 65536 + 32768;
		// March across grid lines; ties go to the y step.
		for (int i = 0; i < 96; i++) begin
			if (sx < sy) begin
				sx += dxd;
				mx += stx;
				side = 0;
			end else begin
				sy += dyd;
				my += sty;
				side = 1;
			end
			if (mx < 0 || my < 0 || mx >= 64 || my >= 64) begin
				oob = 1;
				break;
			end
			c5 = tiles[my * 64 + mx];
			if (c5[4]) begin
				hit = 1;
				kind = c5[3:0];
				break;
			end
		end
		perp = side ? (sy - dyd) : (sx - dxd);
		if (perp < rcw_pkg::MIN_PERP)
			perp = rcw_pkg::MIN_PERP;
		line = (vh << 16) / perp;
		if (line > vh * 8)
			line = vh * 8;
		top_raw = (vh - line) / 2;
		bot_raw = top_raw + line;
		w = side ? pxq + ((perp * rdx) >>> 16) : pyq + ((perp * rdy) >>> 16);
		tx = 32'(((w & 64'hFFFF) * 32) >> 16);
		if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0))
			tx = 32 - tx - 1;
		if (hit && !oob && kind == door_code)
			door = 1;
		n = (tex_count > 16) ? 16 : tex_count;
		num = 64'sd1677721600 - perp * 1536;
		lm = (num < 30 * 6553600) ? 30 : num / 6553600;
		if (side == 1)
			lm = (lm * 180) >> 8;
		r.out_of_map = oob[0];
		r.hit_kind = (hit && !oob) ? kind : 4'd0;
		r.hit_side = side[0];
		r.perp_dist = 23'((perp > rcw_pkg::PERP_CAP) ? rcw_pkg::PERP_CAP : perp);
		r.line_height = 14'(line);
		r.draw_top = 11'((top_raw < 0) ? 0 : top_raw);
		r.draw_bottom = 11'((bot_raw > vh) ? vh : bot_raw);
		r.tex_column = tx[4:0];
		r.is_door = door[0];
		r.texture_index = (!door && n != 0) ? 4'(tile_hash(mx, my) % 32'(n)) : 4'd0;
		r.light = 9'(lm);
		expected_columns.push_back(r);
	endfunction

	function void flag(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $realtime, what);
	endfunction

	function void check_result(column_result_t got);
		column_result_t e;
		if (expected_columns.size() == 0) begin
			flag("result with no cast outstanding");
			return;
		end
		e = expected_columns.pop_front();
		if (got.out_of_map !== e.out_of_map)
			flag($sformatf("out_of_map exp %0d got %0d", e.out_of_map, got.out_of_map));
		if (got.hit_kind !== e.hit_kind)
			flag($sformatf("hit_kind exp %0d got %0d", e.hit_kind, got.hit_kind));
		if (got.hit_side !== e.hit_side)
			flag($sformatf("hit_side exp %0d got %0d", e.hit_side, got.hit_side));
		if (got.perp_dist !== e.perp_dist)
			flag($sformatf("perp_dist exp %0d got %0d", e.perp_dist, got.perp_dist));
		if (got.line_height !== e.line_height)
			flag($sformatf("line_height exp %0d got %0d", e.line_height, got.line_height));
		if (got.draw_top !== e.draw_top)
			flag($sformatf("draw_top exp %0d got %0d", e.draw_top, got.draw_top));
		if (got.draw_bottom !== e.draw_bottom)
			flag($sformatf("draw_bottom exp %0d got %0d", e.draw_bottom, got.draw_bottom));
		if (got.tex_column !== e.tex_column)
			flag($sformatf("tex_column exp %0d got %0d", e.tex_column, got.tex_column));
		if (got.is_door !== e.is_door)
			flag($sformatf("is_door exp %0d got %0d", e.is_door, got.is_door));
		if (got.texture_index !== e.texture_index)
			flag($sformatf("texture_index exp %0d got %0d", e.texture_index,
				got.texture_index));
		if (got.light !== e.light)
			flag($sformatf("light exp %0d got %0d", e.light, got.light));
	endfunction
endclass

module testbench;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        action;
	logic [5:0]  cell_x;
	logic [5:0]  cell_y;
	logic [3:0]  cell_kind;
	logic        cell_blocks;
	logic [9:0]  column;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [10:0] cfg_wdata;
	logic        done;
	column_result_t res;

	column_scoreboard columns = new();
	// Set to keep the command port busy without gaps for a whole phase.
	bit          no_gaps;

	raycast_wall_column_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.cell_x        (cell_x),
		.cell_y        (cell_y),
		.cell_kind     (cell_kind),
		.cell_blocks   (cell_blocks),
		.column        (column),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.done          (done),
		.out_of_map    (res.out_of_map),
		.hit_kind      (res.hit_kind),
		.hit_side      (res.hit_side),
		.perp_dist     (res.perp_dist),
		.line_height   (res.line_height),
		.draw_top      (res.draw_top),
		.draw_bottom   (res.draw_bottom),
		.tex_column    (res.tex_column),
		.is_door       (res.is_door),
		.texture_index (res.texture_index),
		.light         (res.light)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The receiver cannot stall, so every strobed cycle is a result transaction.
	always @(posedge clk) begin
		if (arst_n && done)
			columns.check_result(res);
	end

	// Presents one command and holds it until the block takes it. The start
	// line stays high into the next command unless a gap is drawn, so that
	// back-to-back commands never lower and raise start in the same step.
	task automatic issue(raycast_cmd_t c);
		start       <= 1'b1;
		action      <= c.action;
		cell_x      <= c.cell_x;
		cell_y      <= c.cell_y;
		cell_kind   <= c.cell_kind;
		cell_blocks <= c.cell_blocks;
		column      <= c.column;
		do
			@(posedge clk);
		while (busy);
		columns.note_command(c);
		if (!no_gaps && $urandom_range(99) < 13) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic put_cell(int x, int y, int kind, bit blocks);
		raycast_cmd_t c;
		c = {1'b0, 6'(x), 6'(y), 4'(kind), blocks, 10'($urandom)};
		issue(c);
	endtask

	task automatic cast(int col);
		raycast_cmd_t c;
		c = 28'($urandom);
		c.action = 1'b1;
		c.column = 10'(col);
		issue(c);
	endtask

	// Lets the block drain before registers change. A cast outside the view
	// gives no result, so the task also waits before it trusts busy.
	task automatic settle();
		start <= 1'b0;
		while (columns.expected_columns.size() != 0)
			@(posedge clk);
		repeat (400)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic set_reg(rcw_pkg::cfg_idx_t idx, int v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= 11'(v);
		@(posedge clk);
		columns.write_reg(idx, 11'(v));
	endtask

	task automatic configure(int px, int py, int fx, int fy, int vw, int vh, int nt,
		int dk);
		set_reg(rcw_pkg::CFG_PLAYER_X, px);
		set_reg(rcw_pkg::CFG_PLAYER_Y, py);
		set_reg(rcw_pkg::CFG_FACING_X, fx);
		set_reg(rcw_pkg::CFG_FACING_Y, fy);
		set_reg(rcw_pkg::CFG_VIEW_W, vw);
		set_reg(rcw_pkg::CFG_VIEW_H, vh);
		set_reg(rcw_pkg::CFG_TEX_COUNT, nt);
		set_reg(rcw_pkg::CFG_DOOR_KIND, dk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int vw_eff;
		start       <= 1'b0;
		action      <= 1'b0;
		cell_x      <= '0;
		cell_y      <= '0;
		cell_kind   <= '0;
		cell_blocks <= 1'b0;
		column      <= '0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_wdata   <= '0;
		no_gaps     = 1'b0;
		arst_n      = 1'b0;
		repeat (10)
			@(posedge clk);
		arst_n = 1'b1;

		// Directed part with the reset settings: the player sits in the corner
		// cell looking up, so the first casts leave the map at once.
		cast(0);
		cast(319);
		cast(320);
		cast(1023);
		put_cell(0, 5, 15, 1'b1);
		put_cell(3, 0, 2, 1'b1);
		put_cell(63, 63, 15, 1'b0);
		put_cell(1, 1, 0, 1'b1);
		settle();
		// Looking down +y from the corner towards the wall and the door.
		configure(0, 0, 0, 1, 320, 200, 0, 15);
		cast(0);
		cast(160);
		cast(319);
		settle();
		// Facing code -2 read as -1, wide view, tall view, many textures.
		configure(10, 20, 2, 0, 1023, 2047, 31, 0);
		put_cell(5, 20, 0, 1'b1);
		put_cell(15, 20, 7, 1'b1);
		cast(0);
		cast(320);
		cast(639);
		cast(640);
		settle();
		// Player enclosed on all sides, view of one column and no height.
		configure(63, 63, 0, 0, 0, 0, 16, 7);
		put_cell(62, 63, 7, 1'b1);
		put_cell(63, 62, 3, 1'b1);
		cast(0);
		cast(1);
		settle();

		// Random phases; the third runs without any command gaps.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: configure(32, 32, 1, 0, 640, 1024, 16, 4);
				1: configure($urandom_range(63), $urandom_range(63), 0, 0, 1, 1, 1, 15);
				default: configure($urandom_range(63), $urandom_range(63), $urandom_range(3),
					$urandom_range(3), $urandom_range(1, 1023), $urandom_range(2047),
					$urandom_range(31), $urandom_range(15));
			endcase
			vw_eff = (columns.view_w == 0) ? 1 :
				(columns.view_w > rcw_pkg::MAX_COLUMNS) ? rcw_pkg::MAX_COLUMNS
				: columns.view_w;
			no_gaps = (phase == 2);
			for (int k = 0; k < 210; k++) begin
				if ($urandom_range(99) < 40) begin
					put_cell($urandom_range(63), $urandom_range(63), $urandom_range(15),
						$urandom_range(99) < 35);
				end else if ($urandom_range(99) < 8) begin
					cast($urandom_range(1023));
				end else begin
					cast($urandom_range(vw_eff - 1));
				end
			end
			no_gaps = 1'b0;
			settle();
		end

		if (columns.expected_columns.size() != 0)
			columns.flag("casts left without a result");
		if (columns.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: fails the run if the test does not finish in time.
	initial begin
		#60_000_000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
